### src/sgn_pkg.sv
// ----------------------------------------------------------------------------
// sgn_pkg: shared types and codes for the Sobel gradient / NMS block
// Beat payloads, sequencer states, direction bands and register indexes.
// ----------------------------------------------------------------------------
package sgn_pkg;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] edge_magnitude;
    logic [1:0] direction;
    logic       end_of_line;
    logic       end_of_frame;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRD,
    S_SOB,
    S_SQ,
    S_XY,
    S_ROOT,
    S_GWR,
    S_OUT
  } state_e;

  localparam logic [1:0] DIR_HORZ = 2'd0;
  localparam logic [1:0] DIR_VERT = 2'd1;
  localparam logic [1:0] DIR_ANTI = 2'd2;
  localparam logic [1:0] DIR_DIAG = 2'd3;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int unsigned MinSize = 5;

endpackage

### src/sgn_ram.sv
// ----------------------------------------------------------------------------
// sgn_ram: single-port synchronous RAM
// One access per cycle, read data registered and held until the next read.
// ----------------------------------------------------------------------------
module sgn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/sobel_gradient_nms.sv
// ----------------------------------------------------------------------------
// sobel_gradient_nms: 3x3 Sobel gradient with non-maximum suppression
// A pixel that makes a beat passes through read, Sobel, squares, up to 8 root
// steps, gradient store and output. Input stalls until that pixel is done, so
// the bit-serial root and line store read-modify-write set the pixel rate, and
// an output stall holds it longer.
// Reset: windows, positions and sizes (640x480) clear; line stores hold none.
// ----------------------------------------------------------------------------
module sobel_gradient_nms #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sgn_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sgn_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [12:0]    cfg_data_i
);

  import sgn_pkg::*;

  // Column / row position widths, and compare widths wide enough for both
  // the size registers and the maxima.
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned WCW0 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HCW0 = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WCW  = (WCW0 > 11) ? WCW0 : 11;
  localparam int unsigned HCW  = (HCW0 > 13) ? HCW0 : 13;

  // --------------------------------------------------------------------------
  // Configuration registers: always ready; the source writes only while no
  // beat is in flight.
  // --------------------------------------------------------------------------
  logic [10:0] fw_q;
  logic [12:0] fh_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 11'd640;
      fh_q <= 13'd480;
    end else if (cfg_we) begin
      if (cfg_index_i == REG_FRAME_WIDTH) begin
        fw_q <= cfg_data_i[10:0];
      end else begin
        fh_q <= cfg_data_i;
      end
    end
  end

  // Clamp the sizes into the legal range.
  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;

  always_comb begin
    w_eff = WCW'(fw_q);
    if (w_eff < WCW'(MinSize)) begin
      w_eff = WCW'(MinSize);
    end else if (w_eff > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end
    h_eff = HCW'(fh_q);
    if (h_eff < HCW'(MinSize)) begin
      h_eff = HCW'(MinSize);
    end else if (h_eff > HCW'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_acc;
  logic   out_free;

  logic [CW-1:0] pos_c_q, cur_c_q;
  logic [RW-1:0] pos_r_q, cur_r_q;
  logic [CW-1:0] acc_c;
  logic [RW-1:0] acc_r;
  logic [7:0]    pix_q;

  logic [7:0]  pwin_q [3][3];
  logic [9:0]  gwin_q [3][3];

  logic [9:0]  ax_q, ay_q;
  logic        sx_q, sy_q;
  logic [19:0] axx_q, ayy_q, axy_q;
  logic [20:0] sum_q;
  logic [7:0]  root_q;
  logic [2:0]  k_q;

  logic        out_valid_q;
  out_t        out_q;

  // Line stores: one entry per column, holding the two previous lines.
  logic           pram_we, pram_re, gram_we, gram_re;
  logic [CW-1:0]  pram_addr, gram_addr;
  logic [15:0]    pram_wdata, pram_rdata;
  logic [19:0]    gram_wdata, gram_rdata;

  logic [CW-1:0]  gj;
  logic [RW-1:0]  gi;
  logic           win_ok;
  logic           gwin_ok;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  assign gj      = cur_c_q - CW'(2);
  assign gi      = cur_r_q - RW'(2);
  assign win_ok  = (cur_r_q >= RW'(2)) && (cur_c_q >= CW'(2));
  assign gwin_ok = (gi >= RW'(2)) && (gj >= CW'(2));

  // Position of the beat being accepted: restart on frame start or when the
  // held position lies outside a resized frame.
  always_comb begin
    acc_c = pos_c_q;
    acc_r = pos_r_q;
    if (in_data_i.frame_start || (WCW'(pos_c_q) >= w_eff) ||
        (HCW'(pos_r_q) >= h_eff)) begin
      acc_c = '0;
      acc_r = '0;
    end
  end

  // Sobel sums from the pixel window.
  logic [9:0]  sr, sl, st, sb;
  logic [10:0] gx, gy;

  always_comb begin
    sr = 10'(pwin_q[0][2]) + {1'b0, pwin_q[1][2], 1'b0} + 10'(pwin_q[2][2]);
    sl = 10'(pwin_q[0][0]) + {1'b0, pwin_q[1][0], 1'b0} + 10'(pwin_q[2][0]);
    st = 10'(pwin_q[0][0]) + {1'b0, pwin_q[0][1], 1'b0} + 10'(pwin_q[0][2]);
    sb = 10'(pwin_q[2][0]) + {1'b0, pwin_q[2][1], 1'b0} + 10'(pwin_q[2][2]);
    gx = {1'b0, sr} - {1'b0, sl};
    gy = {1'b0, st} - {1'b0, sb};
  end

  // Direction band by exact integer tangent tests.
  logic [21:0] twice, plus_sq, minus_sq;
  logic [1:0]  band;

  always_comb begin
    twice    = {axx_q, 1'b0, 1'b0} >> 1;
    plus_sq  = 22'(sum_q) + {1'b0, axy_q, 1'b0};
    minus_sq = 22'(sum_q) - {1'b0, axy_q, 1'b0};
    priority if (ax_q == '0) begin
      band = DIR_VERT;
    end else if (plus_sq < twice) begin
      band = DIR_HORZ;
    end else if ((ay_q > ax_q) && (minus_sq > twice)) begin
      band = DIR_VERT;
    end else if (sx_q == sy_q) begin
      band = DIR_DIAG;
    end else begin
      band = DIR_ANTI;
    end
  end

  // One bit of the square root per cycle.
  logic [7:0]  root_try;
  logic [15:0] root_sq;

  assign root_try = root_q | (8'd1 << k_q);
  assign root_sq  = root_try * root_try;

  // Suppression against the two neighbors along the centre band.
  logic [9:0] nb_a, nb_b;
  logic [7:0] centre;
  logic [1:0] cdir;

  always_comb begin
    cdir = gwin_q[1][1][9:8];
    unique case (cdir)
      DIR_HORZ: begin nb_a = gwin_q[1][0]; nb_b = gwin_q[1][2]; end
      DIR_VERT: begin nb_a = gwin_q[0][1]; nb_b = gwin_q[2][1]; end
      DIR_ANTI: begin nb_a = gwin_q[0][2]; nb_b = gwin_q[2][0]; end
      default:  begin nb_a = gwin_q[2][2]; nb_b = gwin_q[0][0]; end
    endcase
    centre = gwin_q[1][1][7:0];
    if ((centre < nb_a[7:0]) || (centre < nb_b[7:0])) begin
      centre = '0;
    end
  end

  // Next state and memory strobes.
  always_comb begin
    state_d    = state_q;
    pram_re    = 1'b0;
    pram_we    = 1'b0;
    pram_addr  = cur_c_q;
    pram_wdata = {pix_q, pram_rdata[15:8]};
    gram_re    = 1'b0;
    gram_we    = 1'b0;
    gram_addr  = gj;
    gram_wdata = {band, root_q, gram_rdata[19:10]};
    unique case (state_q)
      S_IDLE: begin
        pram_addr = acc_c;
        if (in_acc) begin
          pram_re = 1'b1;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        pram_we = 1'b1;
        state_d = win_ok ? S_SOB : S_IDLE;
      end
      S_SOB: begin
        gram_re = 1'b1;
        state_d = S_SQ;
      end
      S_SQ:   state_d = S_XY;
      S_XY:   state_d = S_ROOT;
      S_ROOT: begin
        if ((sum_q[20:16] != '0) || (k_q == '0)) begin
          state_d = S_GWR;
        end
      end
      S_GWR: begin
        gram_we = 1'b1;
        state_d = gwin_ok ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Position counters advance on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_c_q <= '0;
      pos_r_q <= '0;
    end else if (in_acc) begin
      if ((WCW'(acc_c) + WCW'(1)) >= w_eff) begin
        pos_c_q <= '0;
        if ((HCW'(acc_r) + HCW'(1)) >= h_eff) begin
          pos_r_q <= '0;
        end else begin
          pos_r_q <= acc_r + RW'(1);
        end
      end else begin
        pos_c_q <= acc_c + CW'(1);
        pos_r_q <= acc_r;
      end
    end
  end

  // Windows shift one column per pixel / per gradient.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pwin_q[i][j] <= '0;
          gwin_q[i][j] <= '0;
        end
      end
    end else begin
      if (state_q == S_PRD) begin
        for (int i = 0; i < 3; i++) begin
          pwin_q[i][0] <= pwin_q[i][1];
          pwin_q[i][1] <= pwin_q[i][2];
        end
        pwin_q[0][2] <= pram_rdata[7:0];
        pwin_q[1][2] <= pram_rdata[15:8];
        pwin_q[2][2] <= pix_q;
      end
      if (state_q == S_GWR) begin
        for (int i = 0; i < 3; i++) begin
          gwin_q[i][0] <= gwin_q[i][1];
          gwin_q[i][1] <= gwin_q[i][2];
        end
        gwin_q[0][2] <= gram_rdata[9:0];
        gwin_q[1][2] <= gram_rdata[19:10];
        gwin_q[2][2] <= {band, root_q};
      end
    end
  end

  // Per-beat datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q   <= in_data_i.pixel;
      cur_c_q <= acc_c;
      cur_r_q <= acc_r;
    end
    if (state_q == S_SOB) begin
      ax_q <= gx[10] ? 10'(-gx) : gx[9:0];
      ay_q <= gy[10] ? 10'(-gy) : gy[9:0];
      sx_q <= gx[10];
      sy_q <= gy[10];
    end
    if (state_q == S_SQ) begin
      axx_q <= ax_q * ax_q;
      ayy_q <= ay_q * ay_q;
    end
    if (state_q == S_XY) begin
      axy_q  <= ax_q * ay_q;
      sum_q  <= 21'(axx_q) + 21'(ayy_q);
      root_q <= '0;
      k_q    <= 3'd7;
    end
    if (state_q == S_ROOT) begin
      if (sum_q[20:16] != '0) begin
        root_q <= 8'hFF;
      end else begin
        if (root_sq <= sum_q[15:0]) begin
          root_q <= root_try;
        end
        k_q <= k_q - 3'd1;
      end
    end
  end

  // Output register: holds a beat while the sink stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      out_q.edge_magnitude <= centre;
      out_q.direction      <= cdir;
      out_q.end_of_line    <= (WCW'(gj) == (w_eff - WCW'(3)));
      out_q.end_of_frame   <= (WCW'(gj) == (w_eff - WCW'(3))) &&
                              (HCW'(gi) == (h_eff - HCW'(3)));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sgn_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .re_i    (pram_re),
    .addr_i  (pram_addr),
    .wdata_i (pram_wdata),
    .rdata_o (pram_rdata)
  );

  sgn_ram #(
    .WIDTH (20),
    .DEPTH (MAX_WIDTH)
  ) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (gram_we),
    .re_i    (gram_re),
    .addr_i  (gram_addr),
    .wdata_i (gram_wdata),
    .rdata_o (gram_rdata)
  );

endmodule

### tb/sobel_gradient_nms_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_gradient_nms_tb: self-checking bench for the Sobel gradient / NMS block
// Streams pixel frames of many sizes through the block and checks every output
// beat against a cycle-free predictor of the Sobel, root, band and suppression
// math. The frame size registers are rewritten between frames, and both sides
// of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module sobel_gradient_nms_tb;
  import sgn_pkg::*;

  // Predict edge beats from accepted pixels and match them in order.
  class sobel_scoreboard;
    int unsigned frame_w = 640;
    int unsigned frame_h = 480;
    int unsigned col;
    int unsigned row;
    int errors;
    bit [7:0] pix_lines[2048];
    bit [9:0] grad_lines[2048];
    bit [7:0] pix_win[9];
    bit [9:0] grad_win[9];
    out_t edge_q[$];

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < MinSize) return MinSize;
      if (v > hi) return hi;
      return v;
    endfunction

    function bit beyond_frame();
      return col >= clamp_size(frame_w, 1024) || row >= clamp_size(frame_h, 4096);
    endfunction

    function int unsigned floor_root(int unsigned v);
      int unsigned r;
      int unsigned step;
      if (v >= 65536) return 255;
      r = 0;
      for (step = 128; step != 0; step = step >> 1) begin
        if ((r | step) * (r | step) <= v) r = r | step;
      end
      return r;
    endfunction

    // Integer tangent tests at 22.5 and 67.5 degrees.
    function logic [1:0] band_of(int gx, int gy);
      int ax;
      int ay;
      int twice;
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      twice = 2 * ax * ax;
      if (ax == 0) return DIR_VERT;
      if ((ax + ay) * (ax + ay) < twice) return DIR_HORZ;
      if (ay > ax && (ay - ax) * (ay - ax) > twice) return DIR_VERT;
      return ((gx < 0) == (gy < 0)) ? DIR_DIAG : DIR_ANTI;
    endfunction

    function void note_pixel(in_t d);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned gi;
      int unsigned gj;
      int unsigned centre;
      int unsigned a;
      int unsigned b;
      int gx;
      int gy;
      bit [7:0] up1;
      bit [7:0] up2;
      bit [9:0] g;
      bit [9:0] g1;
      bit [9:0] g2;
      logic [1:0] dir;
      out_t e;
      w = clamp_size(frame_w, 1024);
      h = clamp_size(frame_h, 4096);
      c = col;
      r = row;
      if (d.frame_start || c >= w || r >= h) begin
        c = 0;
        r = 0;
      end
      up1 = pix_lines[c];
      up2 = pix_lines[1024 + c];
      pix_lines[1024 + c] = up1;
      pix_lines[c] = d.pixel;
      for (int k = 0; k < 3; k++) begin
        pix_win[k*3] = pix_win[k*3+1];
        pix_win[k*3+1] = pix_win[k*3+2];
      end
      pix_win[2] = up2;
      pix_win[5] = up1;
      pix_win[8] = d.pixel;
      if (r >= 2 && c >= 2) begin
        gx = (int'(pix_win[2]) + 2 * int'(pix_win[5]) + int'(pix_win[8]))
           - (int'(pix_win[0]) + 2 * int'(pix_win[3]) + int'(pix_win[6]));
        gy = (int'(pix_win[0]) + 2 * int'(pix_win[1]) + int'(pix_win[2]))
           - (int'(pix_win[6]) + 2 * int'(pix_win[7]) + int'(pix_win[8]));
        g = {band_of(gx, gy), 8'(floor_root(gx * gx + gy * gy))};
        gi = r - 2;
        gj = c - 2;
        g1 = grad_lines[gj];
        g2 = grad_lines[1024 + gj];
        grad_lines[1024 + gj] = g1;
        grad_lines[gj] = g;
        for (int k = 0; k < 3; k++) begin
          grad_win[k*3] = grad_win[k*3+1];
          grad_win[k*3+1] = grad_win[k*3+2];
        end
        grad_win[2] = g2;
        grad_win[5] = g1;
        grad_win[8] = g;
        if (gi >= 2 && gj >= 2) begin
          centre = grad_win[4][7:0];
          dir = grad_win[4][9:8];
          case (dir)
            DIR_HORZ: begin a = grad_win[3][7:0]; b = grad_win[5][7:0]; end
            DIR_VERT: begin a = grad_win[1][7:0]; b = grad_win[7][7:0]; end
            DIR_ANTI: begin a = grad_win[2][7:0]; b = grad_win[6][7:0]; end
            default:  begin a = grad_win[8][7:0]; b = grad_win[0][7:0]; end
          endcase
          if (centre < a || centre < b) centre = 0;
          e.edge_magnitude = 8'(centre);
          e.direction = dir;
          e.end_of_line = (gj == w - 3);
          e.end_of_frame = (gj == w - 3) && (gi == h - 3);
          edge_q.push_back(e);
        end
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col = c;
      row = r;
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (edge_q.size() == 0) begin
        $display("%0t: unexpected edge beat %h", $time, got);
        errors++;
        return;
      end
      e = edge_q.pop_front();
      if (got.edge_magnitude !== e.edge_magnitude) begin
        $display("%0t: edge_magnitude expected %0d got %0d", $time,
                 e.edge_magnitude, got.edge_magnitude);
        errors++;
      end
      if (got.direction !== e.direction) begin
        $display("%0t: direction expected %0d got %0d", $time, e.direction, got.direction);
        errors++;
      end
      if (got.end_of_line !== e.end_of_line) begin
        $display("%0t: end_of_line expected %0d got %0d", $time,
                 e.end_of_line, got.end_of_line);
        errors++;
      end
      if (got.end_of_frame !== e.end_of_frame) begin
        $display("%0t: end_of_frame expected %0d got %0d", $time,
                 e.end_of_frame, got.end_of_frame);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_FRAME_WIDTH;
  logic [12:0] cfg_data = '0;

  sobel_scoreboard board = new();
  int unsigned send_idle = 19;   // percent of cycles the pixel side idles
  int unsigned recv_idle = 70;   // percent of cycles the edge side stalls
  int unsigned hold_asks = 0;    // long receiver hold-offs requested
  int unsigned hold_done = 0;    // hold-offs taken up by the receiver
  int unsigned hold_left = 0;    // cycles left in the current hold-off
  int unsigned pixels_sent = 0;
  bit          fresh_cfg = 1'b0;

  always #5 clk_i = ~clk_i;

  sobel_gradient_nms u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Receiver: stall at random, or hold off for a long stretch on request.
  always @(posedge clk_i) begin
    if (hold_done != hold_asks) begin
      hold_done <= hold_asks;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Sample mid-cycle; a beat seen here is taken at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) board.check_result(out_data);
  end

  // Offer one pixel beat and hold it until accepted. After a register write
  // the first pixel must restart the frame unless the held position already
  // lies outside it, so no line store entry is read before being written.
  task automatic send_pixel(input logic [7:0] px, input logic fs);
    in_t d;
    bit ok;
    if (fresh_cfg && !board.beyond_frame()) fs = 1'b1;
    fresh_cfg = 1'b0;
    d.pixel = px;
    d.frame_start = fs;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= d;
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk_i);
      ok = !in_stall;
      @(posedge clk_i);
    end
    board.note_pixel(d);
    pixels_sent++;
  endtask

  // Drop valid, wait for every expected edge, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.edge_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[12:0];
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk_i);
      ok = cfg_ready;
      @(posedge clk_i);
    end
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) board.frame_w = val & 'h7ff;
    else board.frame_h = val & 'h1fff;
    fresh_cfg = 1'b1;
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // One frame: flat, black/white, or random content. A few frames omit the
  // frame start (overrun into the next frame) or carry a stray one.
  task automatic run_frame(input int unsigned w, input int unsigned h);
    int unsigned look;
    logic [7:0] level;
    logic [7:0] px;
    bit skip_start;
    look = $urandom_range(9);
    level = 8'($urandom);
    skip_start = ($urandom_range(9) == 0);
    for (int unsigned i = 0; i < w * h; i++) begin
      case (look)
        0: px = level;
        1: px = $urandom_range(1) ? 8'hff : 8'h00;
        default: px = 8'($urandom);
      endcase
      send_pixel(px, (i == 0 && !skip_start) || ($urandom_range(99) < 2));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame, black/white pixels: one beat, saturated magnitudes.
    write_reg(REG_FRAME_WIDTH, 5);
    write_reg(REG_FRAME_HEIGHT, 5);
    for (int i = 0; i < 25; i++) send_pixel($urandom_range(1) ? 8'hff : 8'h00, i == 0);
    // Sizes below the minimum act as 5.
    set_size(0, 0);
    run_frame(5, 5);
    // Width above the maximum acts as 1024: part of a wide first line.
    set_size(2047, 5);
    for (int i = 0; i < 60; i++) send_pixel(8'($urandom), i == 0);
    // Tallest frames, narrow: a partial run of 30 lines.
    set_size(5, 8191);
    for (int i = 0; i < 150; i++) send_pixel(8'($urandom), i == 0);
    // Largest legal sizes, then shrink so the held position falls outside.
    set_size(1024, 4096);
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom), i == 0);
    set_size(7, 5);
    for (int i = 0; i < 35; i++) send_pixel(8'($urandom), 1'b0);

    pixels_sent = 0;
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 19; recv_idle = 70; end
        1: begin send_idle = 70; recv_idle = 19; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      set_size($urandom_range(5, 12), $urandom_range(5, 9));
      if (phase == 2) begin
        // Hold the receiver off long enough for the block to back up.
        hold_asks++;
        run_frame(board.frame_w, board.frame_h);
        run_frame(board.frame_w, board.frame_h);
      end
      while (pixels_sent < 600 * (phase + 1)) begin
        if ($urandom_range(3) == 0) begin
          // Mostly legal sizes; now and then one that clamps to the minimum.
          if ($urandom_range(7) == 0) set_size($urandom_range(0, 4), $urandom_range(0, 4));
          else set_size($urandom_range(5, 12), $urandom_range(5, 9));
        end
        run_frame(board.clamp_size(board.frame_w, 1024),
                  board.clamp_size(board.frame_h, 4096));
      end
      // Pause the sender until every expected beat has come.
      drain();
    end

    in_valid <= 1'b0;
    while (board.edge_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("sobel_gradient_nms_tb: PASS");
    end else begin
      $display("sobel_gradient_nms_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("sobel_gradient_nms_tb: FAIL");
    $finish;
  end

endmodule
